[rtl/ata_pio_lba28_read_sequencer_assert.svh]
// Assertion macros used by the sequencer checker.
`ifndef ATA_PIO_LBA28_READ_SEQUENCER_ASSERT_SVH
`define ATA_PIO_LBA28_READ_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define APLRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define APLRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

[rtl/aplrs_pkg.sv]
// Types and constants shared by the ATA PIO LBA28 read sequencer.
package aplrs_pkg;

  localparam int SPIN_W = 22;
  localparam int LBA_W  = 28;
  localparam int CNT_W  = 9;

  // input commands
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_IDENT  = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_DATA   = 2'd3;

  // bus operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_WR   = 2'd1;
  localparam logic [1:0] OP_RD   = 2'd2;

  // result codes
  localparam logic [3:0] RC_OK          = 4'd0;
  localparam logic [3:0] RC_ABSENT      = 4'd1;
  localparam logic [3:0] RC_BUSY_TMO    = 4'd2;
  localparam logic [3:0] RC_DEV_ERR     = 4'd3;
  localparam logic [3:0] RC_DRQ_TMO     = 4'd4;
  localparam logic [3:0] RC_NO_DEVICE   = 4'd5;
  localparam logic [3:0] RC_ID_ERR      = 4'd6;
  localparam logic [3:0] RC_ID_TMO      = 4'd7;
  localparam logic [3:0] RC_BAD_COUNT   = 4'd8;

  // configuration register indexes
  localparam logic [1:0] REG_BUSY_SPIN   = 2'd0;
  localparam logic [1:0] REG_RD_DRQ_SPIN = 2'd1;
  localparam logic [1:0] REG_ID_DRQ_SPIN = 2'd2;

  localparam logic [SPIN_W-1:0] BUSY_SPIN_RST   = 22'd200000;
  localparam logic [SPIN_W-1:0] RD_DRQ_SPIN_RST = 22'd2000000;
  localparam logic [SPIN_W-1:0] ID_DRQ_SPIN_RST = 22'd500000;

  // task-file ports
  localparam logic [9:0] P_DATA   = 10'h1F0;
  localparam logic [9:0] P_SECCNT = 10'h1F2;
  localparam logic [9:0] P_LBALO  = 10'h1F3;
  localparam logic [9:0] P_LBAMID = 10'h1F4;
  localparam logic [9:0] P_LBAHI  = 10'h1F5;
  localparam logic [9:0] P_DRIVE  = 10'h1F6;
  localparam logic [9:0] P_STATUS = 10'h1F7;
  localparam logic [9:0] P_CTRL   = 10'h3F6;

  // status bits, drive select and command bytes
  localparam logic [7:0] ST_BSY      = 8'h80;
  localparam logic [7:0] ST_DRQ      = 8'h08;
  localparam logic [7:0] ST_ERR      = 8'h01;
  localparam logic [7:0] DRV_MASTER  = 8'hA0;
  localparam logic [7:0] DRV_LBA     = 8'hE0;
  localparam logic [7:0] ATA_READ    = 8'h20;
  localparam logic [7:0] ATA_IDENT   = 8'hEC;

  localparam logic [CNT_W-1:0] MAX_COUNT = 9'd256;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_ID_BSY1  = 9'b000000010,
    PH_ID_PROBE = 9'b000000100,
    PH_ID_BSY2  = 9'b000001000,
    PH_ID_DRQ   = 9'b000010000,
    PH_ID_DATA  = 9'b000100000,
    PH_RD_BSY   = 9'b001000000,
    PH_RD_DRQ   = 9'b010000000,
    PH_RD_DATA  = 9'b100000000
  } phase_t;

  // shape of the result burst caused by one request
  typedef enum logic [2:0] {
    BK_ONE      = 3'd0,
    BK_DATA     = 3'd1,
    BK_ID_START = 3'd2,
    BK_ID_TASK  = 3'd3,
    BK_RD_TASK  = 3'd4
  } burst_kind_t;

  typedef struct packed {
    burst_kind_t      kind;
    logic [1:0]       op;
    logic [9:0]       port;
    logic [7:0]       wv;
    logic [15:0]      dw;
    logic             done;
    logic [3:0]       code;
    logic [31:0]      total;
    logic [LBA_W-1:0] lba;
    logic [7:0]       seccnt;
  } burst_t;

endpackage

[rtl/aplrs_ctl.sv]
// Command sequencer: phase, spin counters, identify capture and burst build.
module aplrs_ctl #(
  parameter int WORDS_PER_SECTOR = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic [1:0]                   in_cmd,
  input  logic [aplrs_pkg::LBA_W-1:0]  in_lba,
  input  logic [aplrs_pkg::CNT_W-1:0]  in_count,
  input  logic [15:0]                  in_reply_value,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [aplrs_pkg::SPIN_W-1:0] cfg_data,
  output logic                         has_res,
  output aplrs_pkg::burst_t            burst
);
  import aplrs_pkg::*;

  localparam int WIDX_W = $clog2(WORDS_PER_SECTOR);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS_PER_SECTOR - 1);
  localparam logic [WIDX_W-1:0] ID_WORD_LO = WIDX_W'(60);
  localparam logic [WIDX_W-1:0] ID_WORD_HI = WIDX_W'(61);

  logic [SPIN_W-1:0] busy_lim_r, rd_drq_lim_r, id_drq_lim_r;
  phase_t            phase_r, phase_nxt;
  logic              present_r, present_nxt;
  logic [SPIN_W-1:0] spin_r, spin_nxt, spin_inc;
  logic [LBA_W-1:0]  lba_r, lba_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt, left_dec;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [15:0]       id_lo_r, id_lo_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [7:0]        st;

  function automatic logic [SPIN_W-1:0] eff(input logic [SPIN_W-1:0] lim);
    eff = (lim == '0) ? SPIN_W'(1) : lim;
  endfunction

  function automatic burst_t single(input logic [1:0] op, input logic [9:0] port,
                                    input logic done, input logic [3:0] code,
                                    input logic [31:0] total);
    burst_t b;
    b        = '0;
    b.kind   = BK_ONE;
    b.op     = op;
    b.port   = port;
    b.done   = done;
    b.code   = code;
    b.total  = done ? total : 32'd0;
    single   = b;
  endfunction

  assign st       = in_reply_value[7:0];
  assign spin_inc = spin_r + SPIN_W'(1);
  assign left_dec = left_r - CNT_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    present_nxt = present_r;
    spin_nxt    = spin_r;
    lba_nxt     = lba_r;
    left_nxt    = left_r;
    widx_nxt    = widx_r;
    id_lo_nxt   = id_lo_r;
    total_nxt   = total_r;
    has_res     = 1'b0;
    burst       = single(OP_NONE, '0, 1'b0, RC_OK, 32'd0);
    if (in_accept) begin
      case (in_cmd)
        CMD_READ: begin
          if (phase_r == PH_IDLE) begin
            has_res = 1'b1;
            if (!present_r) begin
              burst = single(OP_NONE, '0, 1'b1, RC_ABSENT, total_r);
            end else if (in_count > MAX_COUNT) begin
              burst = single(OP_NONE, '0, 1'b1, RC_BAD_COUNT, total_r);
            end else if (in_count == '0) begin
              burst = single(OP_NONE, '0, 1'b1, RC_OK, total_r);
            end else begin
              lba_nxt   = in_lba;
              left_nxt  = in_count;
              spin_nxt  = '0;
              phase_nxt = PH_RD_BSY;
              burst     = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
            end
          end
        end
        CMD_IDENT: begin
          if (phase_r == PH_IDLE) begin
            has_res     = 1'b1;
            present_nxt = 1'b0;
            spin_nxt    = '0;
            phase_nxt   = PH_ID_BSY1;
            burst.kind  = BK_ID_START;
          end
        end
        CMD_STATUS: begin
          case (phase_r)
            PH_ID_BSY1, PH_ID_BSY2: begin
              has_res = 1'b1;
              if ((st & ST_BSY) != '0) begin
                spin_nxt = spin_inc;
                if (spin_inc >= eff(busy_lim_r)) begin
                  phase_nxt = PH_IDLE;
                  burst     = single(OP_NONE, '0, 1'b1, RC_BUSY_TMO, total_r);
                end else begin
                  burst = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
                end
              end else if (phase_r == PH_ID_BSY1) begin
                phase_nxt  = PH_ID_PROBE;
                burst.kind = BK_ID_TASK;
              end else begin
                spin_nxt  = '0;
                phase_nxt = PH_ID_DRQ;
                burst     = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
              end
            end
            PH_ID_PROBE: begin
              has_res = 1'b1;
              if (st == '0) begin
                phase_nxt = PH_IDLE;
                burst     = single(OP_NONE, '0, 1'b1, RC_NO_DEVICE, total_r);
              end else begin
                spin_nxt  = '0;
                phase_nxt = PH_ID_BSY2;
                burst     = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
              end
            end
            PH_ID_DRQ: begin
              has_res = 1'b1;
              if ((st & ST_DRQ) != '0) begin
                widx_nxt  = '0;
                phase_nxt = PH_ID_DATA;
                burst     = single(OP_RD, P_DATA, 1'b0, RC_OK, 32'd0);
              end else if ((st & ST_ERR) != '0) begin
                phase_nxt = PH_IDLE;
                burst     = single(OP_NONE, '0, 1'b1, RC_ID_ERR, total_r);
              end else begin
                spin_nxt = spin_inc;
                if (spin_inc >= eff(id_drq_lim_r)) begin
                  phase_nxt = PH_IDLE;
                  burst     = single(OP_NONE, '0, 1'b1, RC_ID_TMO, total_r);
                end else begin
                  burst = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
                end
              end
            end
            PH_RD_BSY: begin
              has_res = 1'b1;
              if ((st & ST_BSY) != '0) begin
                spin_nxt = spin_inc;
                if (spin_inc >= eff(busy_lim_r)) begin
                  phase_nxt = PH_IDLE;
                  burst     = single(OP_NONE, '0, 1'b1, RC_BUSY_TMO, total_r);
                end else begin
                  burst = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
                end
              end else begin
                spin_nxt     = '0;
                phase_nxt    = PH_RD_DRQ;
                burst.kind   = BK_RD_TASK;
                burst.lba    = lba_r;
                burst.seccnt = left_r[7:0];
              end
            end
            PH_RD_DRQ: begin
              has_res = 1'b1;
              if ((st & ST_ERR) != '0) begin
                phase_nxt = PH_IDLE;
                burst     = single(OP_NONE, '0, 1'b1, RC_DEV_ERR, total_r);
              end else if ((st & ST_BSY) == '0 && (st & ST_DRQ) != '0) begin
                widx_nxt  = '0;
                phase_nxt = PH_RD_DATA;
                burst     = single(OP_RD, P_DATA, 1'b0, RC_OK, 32'd0);
              end else begin
                spin_nxt = spin_inc;
                if (spin_inc >= eff(rd_drq_lim_r)) begin
                  phase_nxt = PH_IDLE;
                  burst     = single(OP_NONE, '0, 1'b1, RC_DRQ_TMO, total_r);
                end else begin
                  burst = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
                end
              end
            end
            default: begin
            end
          endcase
        end
        CMD_DATA: begin
          case (phase_r)
            PH_ID_DATA: begin
              has_res = 1'b1;
              if (widx_r == ID_WORD_LO) id_lo_nxt = in_reply_value;
              if (widx_r == ID_WORD_HI) total_nxt = {in_reply_value, id_lo_r};
              if (widx_r == LAST_WORD) begin
                present_nxt = 1'b1;
                phase_nxt   = PH_IDLE;
                burst       = single(OP_NONE, '0, 1'b1, RC_OK, total_nxt);
              end else begin
                widx_nxt = widx_r + WIDX_W'(1);
                burst    = single(OP_RD, P_DATA, 1'b0, RC_OK, 32'd0);
              end
            end
            PH_RD_DATA: begin
              has_res = 1'b1;
              if (widx_r == LAST_WORD) begin
                left_nxt = left_dec;
                if (left_dec == '0) begin
                  phase_nxt = PH_IDLE;
                  burst     = single(OP_NONE, '0, 1'b1, RC_OK, total_r);
                end else begin
                  spin_nxt  = '0;
                  phase_nxt = PH_RD_DRQ;
                  burst     = single(OP_RD, P_STATUS, 1'b0, RC_OK, 32'd0);
                end
              end else begin
                widx_nxt = widx_r + WIDX_W'(1);
                burst    = single(OP_RD, P_DATA, 1'b0, RC_OK, 32'd0);
              end
              // the sector word goes out ahead of the follow-up result
              burst.kind = BK_DATA;
              burst.dw   = in_reply_value;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_lim_r   <= BUSY_SPIN_RST;
      rd_drq_lim_r <= RD_DRQ_SPIN_RST;
      id_drq_lim_r <= ID_DRQ_SPIN_RST;
      phase_r      <= PH_IDLE;
      present_r    <= 1'b0;
      spin_r       <= '0;
      lba_r        <= '0;
      left_r       <= '0;
      widx_r       <= '0;
      id_lo_r      <= '0;
      total_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BUSY_SPIN:   busy_lim_r   <= cfg_data;
          REG_RD_DRQ_SPIN: rd_drq_lim_r <= cfg_data;
          REG_ID_DRQ_SPIN: id_drq_lim_r <= cfg_data;
          default: begin
          end
        endcase
      end
      phase_r   <= phase_nxt;
      present_r <= present_nxt;
      spin_r    <= spin_nxt;
      lba_r     <= lba_nxt;
      left_r    <= left_nxt;
      widx_r    <= widx_nxt;
      id_lo_r   <= id_lo_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

[rtl/aplrs_emit.sv]
// Result register: holds one burst and plays its results out one per cycle while out_stall is low.
module aplrs_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  aplrs_pkg::burst_t burst,
  output logic              take_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_bus_op,
  output logic [9:0]        out_port,
  output logic [7:0]        out_write_value,
  output logic [15:0]       out_data_word,
  output logic              out_data_valid,
  output logic              out_done_res,
  output logic [3:0]        out_result_code,
  output logic [31:0]       out_sector_total,
  output logic              out_last
);
  import aplrs_pkg::*;

  burst_t     burst_r;
  logic       busy_r;
  logic [2:0] idx_r;
  logic       fire, retire;

  always_comb begin
    out_bus_op       = burst_r.op;
    out_port         = burst_r.port;
    out_write_value  = burst_r.wv;
    out_data_word    = '0;
    out_data_valid   = 1'b0;
    out_done_res     = burst_r.done;
    out_result_code  = burst_r.code;
    out_sector_total = burst_r.total;
    out_last         = 1'b1;
    case (burst_r.kind)
      BK_ONE: begin
      end
      BK_DATA: begin
        out_last = (idx_r == 3'd1);
        if (idx_r == 3'd0) begin
          out_bus_op       = OP_NONE;
          out_port         = '0;
          out_write_value  = '0;
          out_data_word    = burst_r.dw;
          out_data_valid   = 1'b1;
          out_done_res     = 1'b0;
          out_result_code  = RC_OK;
          out_sector_total = '0;
        end
      end
      BK_ID_START, BK_ID_TASK, BK_RD_TASK: begin
        out_done_res     = 1'b0;
        out_result_code  = RC_OK;
        out_sector_total = '0;
        out_bus_op       = OP_RD;
        out_port         = P_STATUS;
        out_write_value  = '0;
        if (burst_r.kind == BK_ID_START) begin
          out_last = (idx_r == 3'd6);
          if (idx_r == 3'd0) begin
            out_bus_op = OP_WR;
            out_port   = P_CTRL;
          end else if (idx_r == 3'd1) begin
            out_bus_op      = OP_WR;
            out_port        = P_DRIVE;
            out_write_value = DRV_MASTER;
          end
        end else if (burst_r.kind == BK_ID_TASK) begin
          out_last = (idx_r == 3'd5);
          if (idx_r <= 3'd3) begin
            out_bus_op = OP_WR;
            out_port   = P_SECCNT + 10'(idx_r);
          end else if (idx_r == 3'd4) begin
            out_bus_op      = OP_WR;
            out_write_value = ATA_IDENT;
          end
        end else begin
          out_last = (idx_r == 3'd6);
          if (idx_r != 3'd6) out_bus_op = OP_WR;
          case (idx_r)
            3'd0: begin
              out_port        = P_DRIVE;
              out_write_value = DRV_LBA | {4'h0, burst_r.lba[27:24]};
            end
            3'd1: begin
              out_port        = P_SECCNT;
              out_write_value = burst_r.seccnt;
            end
            3'd2: begin
              out_port        = P_LBALO;
              out_write_value = burst_r.lba[7:0];
            end
            3'd3: begin
              out_port        = P_LBAMID;
              out_write_value = burst_r.lba[15:8];
            end
            3'd4: begin
              out_port        = P_LBAHI;
              out_write_value = burst_r.lba[23:16];
            end
            3'd5: out_write_value = ATA_READ;
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = busy_r;
  assign fire       = busy_r && !out_stall;
  assign retire     = fire && out_last;
  // take a new request only when the held burst is empty or leaving now
  assign take_stall = busy_r && !retire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (retire) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (fire) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) burst_r <= burst;
  end

endmodule

[rtl/ata_pio_lba28_read_sequencer.sv]
// Top level of the ATA PIO identify and LBA28 read sequencer.
// Each request (start read, start identify, status reply, data reply) is
// decoded in the cycle it is accepted; the phase, spin counter and identify
// capture update at once and the results it causes are loaded into a result
// register that plays them out at one per cycle while out_stall is low. A
// request causing one result (every poll, identify data word, or done) is
// accepted every cycle while out_stall is low; one causing k results (identify
// start 7, identify command setup 6, read setup 7, sector data word 2) holds
// in_stall until its last result leaves. No clearing pass at reset.
// Configuration writes are always ready and take effect on the next request.
module ata_pio_lba28_read_sequencer #(
  parameter int WORDS_PER_SECTOR = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic [aplrs_pkg::LBA_W-1:0]  in_lba,
  input  logic [aplrs_pkg::CNT_W-1:0]  in_count,
  input  logic [15:0]                  in_reply_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_bus_op,
  output logic [9:0]                   out_port,
  output logic [7:0]                   out_write_value,
  output logic [15:0]                  out_data_word,
  output logic                         out_data_valid,
  output logic                         out_done_res,
  output logic [3:0]                   out_result_code,
  output logic [31:0]                  out_sector_total,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [aplrs_pkg::SPIN_W-1:0] cfg_data
);
  import aplrs_pkg::*;

  logic   in_accept;
  logic   has_res;
  burst_t burst;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  aplrs_ctl #(
    .WORDS_PER_SECTOR(WORDS_PER_SECTOR)
  ) u_ctl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_cmd         (in_cmd),
    .in_lba         (in_lba),
    .in_count       (in_count),
    .in_reply_value (in_reply_value),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .has_res        (has_res),
    .burst          (burst)
  );

  aplrs_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_accept && has_res),
    .burst            (burst),
    .take_stall       (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bus_op       (out_bus_op),
    .out_port         (out_port),
    .out_write_value  (out_write_value),
    .out_data_word    (out_data_word),
    .out_data_valid   (out_data_valid),
    .out_done_res     (out_done_res),
    .out_result_code  (out_result_code),
    .out_sector_total (out_sector_total),
    .out_last         (out_last)
  );

endmodule

[rtl/aplrs_chk.sv]
// Port-level checker for the sequencer, bound to the top level.
`include "ata_pio_lba28_read_sequencer_assert.svh"

module aplrs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_bus_op,
  input logic [9:0]  out_port,
  input logic        out_data_valid,
  input logic        out_done_res,
  input logic [3:0]  out_result_code,
  input logic [31:0] out_sector_total,
  input logic        out_last
);
  import aplrs_pkg::*;

  // a stalled result holds
  `APLRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_port) && $stable(out_bus_op) && $stable(out_last))
  // a done result always closes its request's burst
  `APLRS_ASSERT_NOW(a_done_last, out_valid && out_done_res, out_last && out_bus_op == OP_NONE)
  // a sector word never ends a burst and never rides a bus operation
  `APLRS_ASSERT_NOW(a_data_alone, out_valid && out_data_valid,
    !out_last && !out_done_res && out_bus_op == OP_NONE)
  // code and sector total stay zero outside done results
  `APLRS_ASSERT_NOW(a_code_quiet, out_valid && !out_done_res,
    out_result_code == RC_OK && out_sector_total == 32'd0)

endmodule

bind ata_pio_lba28_read_sequencer aplrs_chk u_chk (.*);
